### design/spv_pkg.sv
// Shared types and constants for the sample playback voice.
package spv_pkg;

	// Item payloads
	typedef struct packed {
		logic [2:0]         action;
		logic [15:0]        address;
		logic signed [15:0] sample_word;
		logic [18:0]        rate;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               playing;
	} out_item_t;

	// Action codes
	localparam logic [2:0] ACT_TICK    = 3'd0;
	localparam logic [2:0] ACT_WRITE   = 3'd1;
	localparam logic [2:0] ACT_PLAY    = 3'd2;
	localparam logic [2:0] ACT_RELEASE = 3'd3;
	localparam logic [2:0] ACT_STOP    = 3'd4;
	localparam logic [2:0] ACT_PAUSE   = 3'd5;

	// Register indexes
	localparam logic [2:0] CFG_ATTACK_LEN    = 3'd0;
	localparam logic [2:0] CFG_DECAY_LEN     = 3'd1;
	localparam logic [2:0] CFG_SUSTAIN_LEVEL = 3'd2;
	localparam logic [2:0] CFG_RELEASE_LEN   = 3'd3;
	localparam logic [2:0] CFG_LOOP_ENABLE   = 3'd4;
	localparam logic [2:0] CFG_LOOP_START    = 3'd5;
	localparam logic [2:0] CFG_LOOP_LEN      = 3'd6;
	localparam logic [2:0] CFG_SAMPLE_LEN    = 3'd7;

	// Fixed-point constants
	localparam logic [16:0] FULL_Q16 = 17'h10000;
	localparam logic [18:0] RATE_MAX = 19'd262144;
	localparam logic [23:0] MAX24    = 24'hFFFFFF;

	// Divide by 50 as (x * ceil(2^30 / 50)) >> 30, exact for x below 2^24
	localparam logic [24:0] RECIP_50    = 25'd21474837;
	localparam int          RECIP_SHIFT = 30;

	// Datapath widths
	localparam int DIVD_W = 42;
	localparam int DIVS_W = 33;
	localparam int CNT_W  = 6;
	localparam int IDX_W  = 18;
	localparam int ACC_W  = 40;

	typedef enum logic [1:0] {
		RUN_STOPPED = 2'd0,
		RUN_PLAYING = 2'd1,
		RUN_PAUSED  = 2'd2
	} run_t;

	typedef enum logic [1:0] {
		ENV_ATTACK,
		ENV_DECAY,
		ENV_RELEASE
	} env_kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SMOOTH,
		ST_ENV,
		ST_ENV_W,
		ST_WIN,
		ST_WIN_W,
		ST_SEG,
		ST_SL0,
		ST_SL1,
		ST_SL2,
		ST_AVG,
		ST_AVG_W,
		ST_MUL,
		ST_POS,
		ST_POS_W,
		ST_DONE
	} seq_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quot;
		logic [DIVS_W-1:0] rem;
	} div_rsp_t;

	// Sample store access
	typedef struct packed {
		logic             wr_en;
		logic [15:0]      wr_addr;
		logic [15:0]      wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
	} mem_req_t;

endpackage

### design/spv_div.sv
// Bit-serial restoring divider shared by all divisions of a tick.
module spv_div
	import spv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] quot_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] divisor_q;
	logic [DIVS_W:0]   trial;
	logic              ge;

	// One quotient bit per cycle
	assign trial = {rem_q, quot_q[DIVD_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? DIVS_W'(trial - {1'b0, divisor_q}) : trial[DIVS_W-1:0];
			quot_q <= {quot_q[DIVD_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

### design/spv_store.sv
// Sample word memory with registered, range-checked read.
module spv_store
	import spv_pkg::*;
#(
	parameter int SAMPLE_DEPTH = 65536
)(
	input  logic               clk,
	input  mem_req_t           req,
	input  logic [16:0]        sample_len,
	output logic signed [15:0] rd_word
);

	localparam int AW = $clog2(SAMPLE_DEPTH);

	logic [15:0]   mem [SAMPLE_DEPTH];
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;
	logic          wr_ok;
	logic          rd_ok;
	logic [15:0]   rd_data_q;
	logic          rd_ok_q;

	assign wa    = AW'(req.wr_addr);
	assign ra    = AW'(req.rd_idx);
	assign wr_ok = 32'(req.wr_addr) < 32'(SAMPLE_DEPTH);
	// past the data or past the memory reads as zero
	assign rd_ok = (req.rd_idx < IDX_W'(sample_len)) && (32'(req.rd_idx) < 32'(SAMPLE_DEPTH));

	always_ff @(posedge clk) begin
		if (req.wr_en && wr_ok) begin
			mem[wa] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[ra];
			rd_ok_q   <= rd_ok;
		end
	end

	assign rd_word = rd_ok_q ? $signed(rd_data_q) : 16'sd0;

endmodule

### design/sample_playback_voice.sv
// Sample playback voice: sequencer, envelope, window walk and state.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  input    | in_valid, in_stall, in_item      | in
//  output   | out_valid, out_stall, out_item   | out
//  config   | cfg_we, cfg_index, cfg_data      | in
//
// A tick of a playing voice runs the sequencing states, the average division,
// one more division for each envelope, window fold or position fold that is
// needed, and the window walk over its sample slices (one to five slices, split
// in two segments when the window wraps to the loop start). Any other item goes
// straight to the done state. Reset clears the voice state; the sample
// store has no clearing pass and holds garbage until written.
// A stalled output holds in its register; the next item is taken meanwhile.
module sample_playback_voice
	import spv_pkg::*;
#(
	parameter int SAMPLE_DEPTH = 65536
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	// Configuration
	logic [23:0] attack_q, decay_q, release_q;
	logic [16:0] sustain_q, loop_len_q, sample_len_q;
	logic        loop_en_q;
	logic [15:0] loop_start_q;

	// Voice state
	logic [31:0] position_q;
	logic [23:0] elapsed_q, rel_elapsed_q;
	logic [18:0] smooth_rate_q;
	logic        seeded_q;
	logic [16:0] release_from_q;
	logic        releasing_q;
	run_t        run_q;

	// Sequencer and work registers
	seq_t               state_q, state_d;
	in_item_t           item_q;
	logic [16:0]        env_q;
	logic               alive_q;
	env_kind_t          env_kind_q;
	logic               sign_q;
	logic [33:0]        ws_q;
	logic [34:0]        cur_q, b_q, seg1_a_q, seg1_b_q;
	logic               seg1_pend_q;
	logic signed [15:0] w0_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [15:0] avg_q;
	logic signed [33:0] prod_q;
	logic [32:0]        np_q;
	logic signed [15:0] res_q;
	out_item_t          out_q;
	logic               out_valid_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	mem_req_t mem_req;
	logic signed [15:0] rd_word;

	// Derived values
	logic              in_fire, out_free;
	logic [16:0]       sus_eff, ll_n;
	logic [33:0]       lb_w, ll_w, le_w;
	logic [18:0]       target, rate_mag;
	logic              rate_neg;
	logic [25:0]       step_mag;
	logic [50:0]       smooth_prod;
	logic [18:0]       smooth_adj;
	logic [23:0]       e_dec;
	logic              in_attack, in_decay;
	logic [34:0]       we_w;
	logic [IDX_W-1:0]  slice_idx;
	logic [34:0]       slice_nxt, slice_end;
	logic [16:0]       slice_len;
	logic signed [16:0] pair_sum;
	logic signed [34:0] slice_prod;
	logic [ACC_W-1:0]  acc_mag;
	logic [33:0]       prod_mag;
	logic [17:0]       rnd_mag;
	logic [33:0]       fold_pos;

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign sus_eff = (sustain_q > FULL_Q16) ? FULL_Q16 : sustain_q;
	assign ll_n    = (loop_len_q == 17'd0) ? 17'd1 :
		((loop_len_q > FULL_Q16) ? FULL_Q16 : loop_len_q);
	assign lb_w    = {2'b00, loop_start_q, 16'h0000};
	assign ll_w    = {1'b0, ll_n, 16'h0000};
	assign le_w    = lb_w + ll_w;

	// Rate smoothing: rounded 49/50 of the difference, by reciprocal multiply
	assign target      = (item_q.rate == 19'd0) ? 19'd1 :
		((item_q.rate > RATE_MAX) ? RATE_MAX : item_q.rate);
	assign rate_neg    = target < smooth_rate_q;
	assign rate_mag    = rate_neg ? (smooth_rate_q - target) : (target - smooth_rate_q);
	assign step_mag    = 26'(rate_mag) * 26'd49;
	assign smooth_prod = 51'(step_mag + 26'd25) * 51'(RECIP_50);
	assign smooth_adj  = smooth_prod[RECIP_SHIFT +: 19];

	// Envelope phase
	assign e_dec     = elapsed_q - attack_q;
	assign in_attack = elapsed_q < attack_q;
	assign in_decay  = e_dec < decay_q;

	// Window slice
	assign we_w       = 35'(ws_q) + 35'(smooth_rate_q);
	assign slice_idx  = cur_q[33:16];
	assign slice_nxt  = {1'b0, slice_idx + 1'b1, 16'h0000};
	assign slice_end  = (slice_nxt < b_q) ? slice_nxt : b_q;
	assign slice_len  = 17'(slice_end - cur_q);
	assign pair_sum   = 17'(w0_q) + 17'(rd_word);
	assign slice_prod = pair_sum * $signed({1'b0, slice_len});
	assign acc_mag    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

	// Output rounding, half away from zero
	assign prod_mag = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
	assign rnd_mag  = 18'((prod_mag + 34'd32768) >> 16);
	assign fold_pos = 34'(div_rsp.rem) + lb_w;

	// Shared divider and sample store
	spv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	spv_store #(
		.SAMPLE_DEPTH (SAMPLE_DEPTH)
	) u_store (
		.clk        (clk),
		.req        (mem_req),
		.sample_len (sample_len_q),
		.rd_word    (rd_word)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, divider requests, memory requests
	always_comb begin
		state_d  = state_q;
		div_req  = '0;
		mem_req  = '0;
		in_stall = state_q != ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					mem_req.wr_en   = in_item.action == ACT_WRITE;
					mem_req.wr_addr = in_item.address;
					mem_req.wr_data = in_item.sample_word;
					if (in_item.action == ACT_TICK && run_q == RUN_PLAYING) begin
						state_d = ST_SMOOTH;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SMOOTH: begin
				state_d = ST_ENV;
			end
			ST_ENV: begin
				if (releasing_q) begin
					if (release_q == 24'd0) begin
						state_d = ST_WIN;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = DIVD_W'(41'(rel_elapsed_q) * 41'(sus_eff));
						div_req.divisor  = DIVS_W'(release_q);
						state_d          = ST_ENV_W;
					end
				end else if (in_attack) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIVD_W'({elapsed_q, 16'h0000});
					div_req.divisor  = DIVS_W'(attack_q);
					state_d          = ST_ENV_W;
				end else if (in_decay) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIVD_W'(41'(e_dec) * 41'(FULL_Q16 - sus_eff));
					div_req.divisor  = DIVS_W'(decay_q);
					state_d          = ST_ENV_W;
				end else begin
					state_d = ST_WIN;
				end
			end
			ST_ENV_W: begin
				if (div_rsp.done) state_d = ST_WIN;
			end
			ST_WIN: begin
				if (loop_en_q && {2'b00, position_q} > lb_w) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIVD_W'(position_q - lb_w[31:0]);
					div_req.divisor  = ll_w[DIVS_W-1:0];
					state_d          = ST_WIN_W;
				end else begin
					state_d = ST_SEG;
				end
			end
			ST_WIN_W: begin
				if (div_rsp.done) state_d = ST_SEG;
			end
			ST_SEG: begin
				state_d = ST_SL0;
			end
			ST_SL0: begin
				if (cur_q < b_q) begin
					mem_req.rd_en  = 1'b1;
					mem_req.rd_idx = slice_idx;
					state_d        = ST_SL1;
				end else if (!seg1_pend_q) begin
					state_d = ST_AVG;
				end
			end
			ST_SL1: begin
				mem_req.rd_en  = 1'b1;
				mem_req.rd_idx = slice_idx + 1'b1;
				state_d        = ST_SL2;
			end
			ST_SL2: begin
				state_d = ST_SL0;
			end
			ST_AVG: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIVD_W'(acc_mag);
				div_req.divisor  = DIVS_W'({smooth_rate_q, 1'b0});
				state_d          = ST_AVG_W;
			end
			ST_AVG_W: begin
				if (div_rsp.done) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_POS;
			end
			ST_POS: begin
				if (loop_en_q && 34'(np_q) > lb_w) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIVD_W'(34'(np_q) - lb_w);
					div_req.divisor  = ll_w[DIVS_W-1:0];
					state_d          = ST_POS_W;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_POS_W: begin
				if (div_rsp.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q     <= '0;
			decay_q      <= '0;
			sustain_q    <= FULL_Q16;
			release_q    <= '0;
			loop_en_q    <= 1'b0;
			loop_start_q <= '0;
			loop_len_q   <= 17'd1;
			sample_len_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ATTACK_LEN:    attack_q     <= cfg_data;
				CFG_DECAY_LEN:     decay_q      <= cfg_data;
				CFG_SUSTAIN_LEVEL: sustain_q    <= cfg_data[16:0];
				CFG_RELEASE_LEN:   release_q    <= cfg_data;
				CFG_LOOP_ENABLE:   loop_en_q    <= cfg_data[0];
				CFG_LOOP_START:    loop_start_q <= cfg_data[15:0];
				CFG_LOOP_LEN:      loop_len_q   <= cfg_data[16:0];
				CFG_SAMPLE_LEN:    sample_len_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Voice state: actions and updates during a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q     <= '0;
			elapsed_q      <= '0;
			rel_elapsed_q  <= '0;
			smooth_rate_q  <= '0;
			seeded_q       <= 1'b0;
			release_from_q <= '0;
			releasing_q    <= 1'b0;
			run_q          <= RUN_STOPPED;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_item.action)
							ACT_PLAY: begin
								if (run_q != RUN_PAUSED) begin
									position_q     <= '0;
									elapsed_q      <= '0;
									rel_elapsed_q  <= '0;
									releasing_q    <= 1'b0;
									release_from_q <= '0;
								end
								run_q <= RUN_PLAYING;
							end
							ACT_RELEASE: begin
								if (run_q == RUN_PLAYING && !releasing_q) begin
									releasing_q   <= 1'b1;
									rel_elapsed_q <= '0;
								end
							end
							ACT_STOP: begin
								run_q          <= RUN_STOPPED;
								position_q     <= '0;
								elapsed_q      <= '0;
								rel_elapsed_q  <= '0;
								releasing_q    <= 1'b0;
								release_from_q <= '0;
							end
							ACT_PAUSE: begin
								if (run_q == RUN_PLAYING) run_q <= RUN_PAUSED;
							end
							default: ;
						endcase
					end
				end
				ST_SMOOTH: begin
					if (!seeded_q) begin
						smooth_rate_q <= target;
						seeded_q      <= 1'b1;
					end else begin
						smooth_rate_q <= rate_neg ? (smooth_rate_q - smooth_adj) :
							(smooth_rate_q + smooth_adj);
					end
				end
				ST_ENV: begin
					if (!releasing_q && !in_attack && !in_decay) begin
						release_from_q <= sus_eff;
					end
				end
				ST_ENV_W: begin
					if (div_rsp.done) begin
						if (env_kind_q == ENV_ATTACK) begin
							release_from_q <= div_rsp.quot[16:0];
						end else if (env_kind_q == ENV_DECAY) begin
							release_from_q <= FULL_Q16 - div_rsp.quot[16:0];
						end
					end
				end
				ST_MUL: begin
					if (elapsed_q != MAX24) elapsed_q <= elapsed_q + 1'b1;
					if (releasing_q && rel_elapsed_q != MAX24) begin
						rel_elapsed_q <= rel_elapsed_q + 1'b1;
					end
					if (!alive_q) run_q <= RUN_STOPPED;
				end
				ST_POS: begin
					if (!loop_en_q) begin
						if (run_q == RUN_PLAYING && np_q >= {sample_len_q, 16'h0000}) begin
							run_q <= RUN_STOPPED;
						end
						position_q <= np_q[32] ? 32'hFFFF_FFFF : np_q[31:0];
					end else if (34'(np_q) <= lb_w) begin
						position_q <= np_q[32] ? 32'hFFFF_FFFF : np_q[31:0];
					end
				end
				ST_POS_W: begin
					if (div_rsp.done) begin
						position_q <= (fold_pos[33:32] != 2'b00) ? 32'hFFFF_FFFF :
							fold_pos[31:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Work registers of one tick
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					item_q <= in_item;
					res_q  <= 16'sd0;
				end
			end
			ST_ENV: begin
				alive_q <= !(releasing_q && release_q == 24'd0);
				if (releasing_q) begin
					env_kind_q <= ENV_RELEASE;
					if (release_q == 24'd0) begin
						env_q <= '0;
					end
				end else if (in_attack) begin
					env_kind_q <= ENV_ATTACK;
				end else if (in_decay) begin
					env_kind_q <= ENV_DECAY;
				end else begin
					env_q <= sus_eff;
				end
			end
			ST_ENV_W: begin
				if (div_rsp.done) begin
					unique case (env_kind_q)
						ENV_ATTACK: env_q <= div_rsp.quot[16:0];
						ENV_DECAY:  env_q <= FULL_Q16 - div_rsp.quot[16:0];
						ENV_RELEASE: begin
							if (div_rsp.quot >= DIVD_W'(release_from_q)) begin
								alive_q <= 1'b0;
								env_q   <= '0;
							end else begin
								env_q <= release_from_q - div_rsp.quot[16:0];
							end
						end
						default: env_q <= '0;
					endcase
				end
			end
			ST_WIN: begin
				ws_q <= {2'b00, position_q};
			end
			ST_WIN_W: begin
				if (div_rsp.done) ws_q <= fold_pos;
			end
			ST_SEG: begin
				acc_q       <= '0;
				seg1_pend_q <= 1'b0;
				if (loop_en_q && 34'(smooth_rate_q) > ll_w) begin
					// window wider than the loop: take the whole loop
					cur_q <= 35'(lb_w);
					b_q   <= 35'(le_w);
				end else if (loop_en_q && we_w > 35'(le_w)) begin
					// part past the loop end wraps to the loop start
					cur_q       <= 35'(ws_q);
					b_q         <= 35'(le_w);
					seg1_a_q    <= 35'(lb_w);
					seg1_b_q    <= 35'(lb_w) + (we_w - 35'(le_w));
					seg1_pend_q <= 1'b1;
				end else begin
					cur_q <= 35'(ws_q);
					b_q   <= we_w;
				end
			end
			ST_SL0: begin
				if (cur_q >= b_q && seg1_pend_q) begin
					cur_q       <= seg1_a_q;
					b_q         <= seg1_b_q;
					seg1_pend_q <= 1'b0;
				end
			end
			ST_SL1: begin
				w0_q <= rd_word;
			end
			ST_SL2: begin
				acc_q <= acc_q + ACC_W'(slice_prod);
				cur_q <= slice_end;
			end
			ST_AVG: begin
				sign_q <= acc_q[ACC_W-1];
			end
			ST_AVG_W: begin
				if (div_rsp.done) begin
					if (sign_q) begin
						avg_q <= (div_rsp.quot > DIVD_W'(32768)) ? 16'sh8000 :
							16'(DIVD_W'(0) - div_rsp.quot);
					end else begin
						avg_q <= (div_rsp.quot > DIVD_W'(32767)) ? 16'sh7FFF :
							div_rsp.quot[15:0];
					end
				end
			end
			ST_MUL: begin
				prod_q <= avg_q * $signed({1'b0, env_q});
				np_q   <= 33'(position_q) + 33'(smooth_rate_q);
			end
			ST_POS: begin
				if (prod_q[33]) begin
					res_q <= (rnd_mag > 18'd32768) ? 16'sh8000 : 16'(18'd0 - rnd_mag);
				end else begin
					res_q <= (rnd_mag > 18'd32767) ? 16'sh7FFF : rnd_mag[15:0];
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q.sample_out <= res_q;
			out_q.playing    <= run_q == RUN_PLAYING;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
